@@ rtl/aoss_pkg.sv @@
package aoss_pkg;

  localparam int unsigned ChanW    = 4;
  localparam int unsigned WaitW    = 10;
  localparam int unsigned PadW     = 12;
  localparam int unsigned TsensW   = 8;
  localparam int unsigned TdataInW  = 32;
  localparam int unsigned TdataOutW = 32;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [ChanW-1:0] NO_OWNER = 4'd15;
  localparam logic [ChanW-1:0] TEMP_CH  = 4'd10;

  localparam logic [WaitW-1:0] SHORT_WAIT_RST  = 10'd5;
  localparam logic [WaitW-1:0] WARMUP_WAIT_RST = 10'd300;

  localparam logic [CfgIdxW-1:0] CFG_SHORT_WAIT  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_WARMUP_WAIT = 1'b1;

  typedef enum logic [1:0] {
    ACT_POLL   = 2'd0,
    ACT_READ   = 2'd1,
    ACT_CANCEL = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    PWR_KEEP = 2'd0,
    PWR_ON   = 2'd1,
    PWR_OFF  = 2'd2
  } power_e;

  typedef enum logic [1:0] {
    CAP_KEEP = 2'd0,
    CAP_SET  = 2'd1,
    CAP_CLR  = 2'd2
  } capture_e;

  // request fields, highest bit first
  typedef struct packed {
    logic [TsensW-1:0] tsens_raw;
    logic [PadW-1:0]   pad_raw;
    logic              conv_busy;
    logic              tsens_ready;
    logic              conv_done;
    logic [ChanW-1:0]  channel;
    logic [1:0]        action;
  } req_t;

  // response fields, highest bit first
  typedef struct packed {
    logic              fault;
    logic [1:0]        tsens_capture;
    logic              stop_conv;
    logic              start_conv;
    logic [1:0]        power_cmd;
    logic [PadW-1:0]   value;
    logic [WaitW-1:0]  wait_us;
  } rsp_t;

endpackage

@@ rtl/aoss_scale.sv @@
module aoss_scale (
  input  logic [aoss_pkg::TsensW-1:0] tsens_raw_i,
  output logic [aoss_pkg::PadW-1:0]   value_o
);
  import aoss_pkg::*;

  // raw*4095 = raw*255*16 + raw*15, so result = 16*raw + (15*raw + 127) / 255
  logic [11:0] rem_num;
  logic [12:0] rem_inc;
  logic [21:0] rem_mul;
  logic [3:0]  rem_quo;

  always_comb begin
    rem_num = ({4'd0, tsens_raw_i} << 4) - {4'd0, tsens_raw_i} + 12'd127;
    rem_inc = {1'b0, rem_num} + 13'd1;
    // divide by 255 as (x+1)*257 >> 16, exact for x below 65280
    rem_mul = ({9'd0, rem_inc} << 8) + {9'd0, rem_inc};
    rem_quo = rem_mul[19:16];
    value_o = {tsens_raw_i, 4'd0} + {8'd0, rem_quo};
  end

endmodule

@@ rtl/aoss_ctrl.sv @@
module aoss_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  aoss_pkg::req_t             req_i,
  input  logic [aoss_pkg::WaitW-1:0] short_wait_i,
  input  logic [aoss_pkg::WaitW-1:0] warmup_wait_i,
  input  logic [aoss_pkg::PadW-1:0]  temp_value_i,
  output aoss_pkg::rsp_t             rsp_o
);
  import aoss_pkg::*;

  logic [ChanW-1:0] owner_q, owner_d;
  logic             warmed_q, warmed_d;
  logic             cap_q, cap_d;

  logic     valid_ch;
  logic     owns;
  logic     is_temp;
  power_e   power;
  capture_e capture;

  always_comb begin
    valid_ch = (req_i.channel <= TEMP_CH);
    owns     = valid_ch && (owner_q == req_i.channel);
    is_temp  = (req_i.channel == TEMP_CH);

    owner_d  = owner_q;
    warmed_d = warmed_q;
    cap_d    = cap_q;
    power    = PWR_KEEP;
    capture  = CAP_KEEP;
    rsp_o    = '0;

    unique case (action_e'(req_i.action))
      ACT_POLL: begin
        rsp_o.wait_us = short_wait_i;
        if (owns) begin
          if (is_temp) begin
            if (!cap_q) begin
              capture = CAP_SET;
              cap_d   = 1'b1;
            end else if (req_i.tsens_ready) begin
              rsp_o.wait_us = '0;
            end
          end else if (req_i.conv_done) begin
            rsp_o.wait_us = '0;
          end
        end else if (valid_ch && (owner_q == NO_OWNER)) begin
          if (is_temp) begin
            owner_d = req_i.channel;
            cap_d   = 1'b0;
            if (!warmed_q) begin
              warmed_d      = 1'b1;
              rsp_o.wait_us = warmup_wait_i;
            end else begin
              capture = CAP_SET;
              cap_d   = 1'b1;
            end
          end else if (!req_i.conv_busy) begin
            power            = PWR_ON;
            rsp_o.start_conv = 1'b1;
            owner_d          = req_i.channel;
          end
        end
      end
      ACT_READ: begin
        if (!owns) begin
          rsp_o.fault = 1'b1;
        end else if (is_temp) begin
          rsp_o.value = temp_value_i;
          capture     = CAP_CLR;
          owner_d     = NO_OWNER;
          cap_d       = 1'b0;
        end else begin
          rsp_o.value = req_i.pad_raw;
          power       = PWR_OFF;
          owner_d     = NO_OWNER;
        end
      end
      ACT_CANCEL: begin
        if (owns) begin
          if (is_temp) begin
            capture = CAP_CLR;
            cap_d   = 1'b0;
          end else begin
            rsp_o.stop_conv = 1'b1;
            power           = PWR_OFF;
          end
          owner_d = NO_OWNER;
        end
      end
      default: begin
      end
    endcase

    rsp_o.power_cmd     = power;
    rsp_o.tsens_capture = capture;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_q  <= NO_OWNER;
      warmed_q <= 1'b0;
      cap_q    <= 1'b0;
    end else if (fire_i) begin
      owner_q  <= owner_d;
      warmed_q <= warmed_d;
      cap_q    <= cap_d;
    end
  end

endmodule

@@ rtl/adc_oneshot_sample_sequencer.sv @@
// channel   dir  signals                         payload
// request   in   s_axis_tvalid/tready/tdata      action, channel, flags, raw data
// response  out  m_axis_tvalid/tready/tdata      wait, value, commands, fault
// config    in   cfg_we_i/cfg_idx_i/cfg_data_i   short and warm-up waits
//
// two-register pipeline: a request beat lands in the input register, the
// ownership decision and sensor scaling run combinationally into the output
// register, so one beat per cycle flows through while responses are taken
// the output register moves only when empty or drained; a stalled response
// holds the input register and drops s_axis_tready only once it is also full
// reset (async, active low) frees the converter, clears warm-up and capture
// flags and loads the default waits of 5 us and 300 us
module adc_oneshot_sample_sequencer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request beat
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [1:0] action, [5:2] channel, [6] conv_done, [7] tsens_ready,
  // [8] conv_busy, [20:9] pad_raw, [28:21] tsens_raw, [31:29] zero
  input  logic [aoss_pkg::TdataInW-1:0]     s_axis_tdata,
  // response beat
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [9:0] wait_us, [21:10] value, [23:22] power_cmd, [24] start_conv,
  // [25] stop_conv, [27:26] tsens_capture, [28] fault, [31:29] zero
  output logic [aoss_pkg::TdataOutW-1:0]    m_axis_tdata,
  // register writes
  input  logic                              cfg_we_i,
  input  logic [aoss_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [aoss_pkg::WaitW-1:0]        cfg_data_i
);
  import aoss_pkg::*;

  localparam int unsigned ReqW = $bits(req_t);
  localparam int unsigned RspW = $bits(rsp_t);

  logic             in_vld_q;
  req_t             in_req_q;
  logic             out_vld_q;
  rsp_t             out_rsp_q;
  logic [WaitW-1:0] short_wait_q;
  logic [WaitW-1:0] warmup_wait_q;

  logic             advance;
  logic             fire;
  logic [PadW-1:0]  temp_value;
  rsp_t             rsp;

  // pipeline moves when the output slot is empty or being drained
  assign advance       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || advance;
  assign fire          = in_vld_q && advance;

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(TdataOutW-RspW){1'b0}}, out_rsp_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_wait_q  <= SHORT_WAIT_RST;
      warmup_wait_q <= WARMUP_WAIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SHORT_WAIT:  short_wait_q  <= cfg_data_i;
        CFG_WARMUP_WAIT: warmup_wait_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_req_q <= req_t'(s_axis_tdata[ReqW-1:0]);
    end
  end

  aoss_scale u_scale (
    .tsens_raw_i (in_req_q.tsens_raw),
    .value_o     (temp_value)
  );

  // ownership state and per-beat decision
  aoss_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .req_i         (in_req_q),
    .short_wait_i  (short_wait_q),
    .warmup_wait_i (warmup_wait_q),
    .temp_value_i  (temp_value),
    .rsp_o         (rsp)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_rsp_q <= rsp;
    end
  end

endmodule
